@@ sv/pts_pkg.sv @@
// Shared constants, types and helpers for the preemptive priority task scheduler.
package pts_pkg;

    localparam int FIFO_DEPTH  = 16;
    localparam int STACK_DEPTH = 16;
    localparam int NUM_FIFOS   = 3;

    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);
    localparam int FMEM_DEPTH = NUM_FIFOS * FIFO_DEPTH;
    localparam int FMAW       = $clog2(FMEM_DEPTH);
    localparam int SPW        = $clog2(STACK_DEPTH);
    localparam int SLW        = $clog2(STACK_DEPTH + 1);
    localparam int QSW        = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;

    localparam int QIDX_W  = 2;
    localparam int PRIO_W  = 8;
    localparam int DUR_W   = 16;
    localparam int STAT_W  = 2;
    localparam int SRC_W   = 3;
    localparam int COUNT_W = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_QFULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_SFULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

    localparam logic [SRC_W-1:0] SRC_NONE  = 3'd0;
    localparam logic [SRC_W-1:0] SRC_STACK = 3'd4;

    localparam logic [DUR_W-1:0] TICK_RESET = 16'd1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DUR_W-1:0]  dur;
    } task_t;

    typedef struct packed {
        logic           is_tick;
        logic           drop;
        logic [QSW-1:0] qsel;
        task_t          tsk;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               running_valid;
        logic [PRIO_W-1:0]  running_priority;
        logic [DUR_W-1:0]   running_remaining;
        logic               finished;
        logic [SRC_W-1:0]   run_source;
        logic [COUNT_W-1:0] stack_count;
    } result_t;

    function automatic logic [FPW-1:0] fptr_inc(input logic [FPW-1:0] ptr);
        if (ptr == FPW'(FIFO_DEPTH - 1))
            return '0;
        else
            return ptr + 1'b1;
    endfunction

endpackage

@@ sv/pts_front.sv @@
// Front end: accepts transactions, classifies them and queues them for the engine.
module pts_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   command,
    input  logic [1:0]             queue_index,
    input  logic [7:0]             task_priority,
    input  logic [15:0]            task_duration,
    output logic                   cmd_valid,
    output pts_pkg::cmd_t          cmd,
    input  logic                   cmd_pop
);
    import pts_pkg::*;

    localparam int QD = 2;

    cmd_t       q_mem [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push;

    always_comb
    begin
        cls.is_tick  = (command == CMD_TICK);
        cls.drop     = (32'(queue_index) >= 32'(NUM_FIFOS));
        cls.qsel     = QSW'(queue_index);
        cls.tsk.prio = task_priority;
        cls.tsk.dur  = task_duration;
    end

    assign in_ready  = (cnt_reg != 2'(QD));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/pts_engine.sv @@
// Back end: task FIFOs, preemption stack, running task and result register.
module pts_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [15:0]            cfg_write_data,
    input  logic                   cmd_valid,
    input  pts_pkg::cmd_t          cmd,
    output logic                   cmd_pop,
    output logic                   res_valid,
    output pts_pkg::result_t       res,
    input  logic                   res_ready
);
    import pts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    task_t fifo_mem  [FMEM_DEPTH];
    task_t stack_mem [STACK_DEPTH];

    logic              state_reg, state_next;
    logic [FPW-1:0]    head_reg [NUM_FIFOS];
    logic [FPW-1:0]    head_next [NUM_FIFOS];
    logic [FPW-1:0]    tail_reg [NUM_FIFOS];
    logic [FPW-1:0]    tail_next [NUM_FIFOS];
    logic [FCW-1:0]    count_reg [NUM_FIFOS];
    logic [FCW-1:0]    count_next [NUM_FIFOS];
    logic [SLW-1:0]    level_reg, level_next;
    logic              busy_reg, busy_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [DUR_W-1:0]  tick_amount_reg;
    logic              popped_reg;
    logic [QSW-1:0]    sel_reg;
    task_t             fifo_rd_reg;
    task_t             stack_rd_reg;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              slot_free;
    logic              idle_go;
    logic              tick_go;
    logic              enq_do;
    logic              enq_full;
    logic              exec_done;
    logic              found;
    logic [QSW-1:0]    sel;
    logic [FMAW-1:0]   fifo_raddr;
    logic [FMAW-1:0]   fifo_waddr;
    logic [SPW-1:0]    stack_raddr;
    logic              push_do;
    task_t             push_data;
    logic              stack_full;
    logic [STAT_W-1:0] ex_status;
    logic [SRC_W-1:0]  ex_src;
    logic              ex_finished;
    logic              t_busy;
    logic [PRIO_W-1:0] t_prio;
    logic [DUR_W-1:0]  t_rem;

    assign slot_free = !out_valid_reg || res_ready;
    assign idle_go   = (state_reg == S_IDLE) && cmd_valid && (cmd.is_tick || slot_free);
    assign cmd_pop   = idle_go;
    assign tick_go   = idle_go && cmd.is_tick;
    assign enq_full  = (count_reg[cmd.qsel] >= FCW'(FIFO_DEPTH));
    assign enq_do    = idle_go && !cmd.is_tick && !cmd.drop && !enq_full;
    assign exec_done = (state_reg == S_EXEC) && slot_free;
    assign stack_full = (level_reg == SLW'(STACK_DEPTH));

    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_FIFOS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                found = 1'b1;
                sel   = QSW'(i);
            end
        end
    end

    assign fifo_raddr  = FMAW'(int'(sel) * FIFO_DEPTH + int'(head_reg[sel]));
    assign fifo_waddr  = FMAW'(int'(cmd.qsel) * FIFO_DEPTH + int'(tail_reg[cmd.qsel]));
    assign stack_raddr = (level_reg == '0) ? '0 : SPW'(level_reg - 1'b1);

    always_comb
    begin
        for (int i = 0; i < NUM_FIFOS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (enq_do && (cmd.qsel == QSW'(i)))
            begin
                tail_next[i]  = fptr_inc(tail_reg[i]);
                count_next[i] = count_reg[i] + 1'b1;
            end
            if (tick_go && found && (sel == QSW'(i)))
            begin
                head_next[i]  = fptr_inc(head_reg[i]);
                count_next[i] = count_reg[i] - 1'b1;
            end
        end
    end

    // Tick decision: preempt, resume or continue, then burn tick_amount.
    always_comb
    begin
        t_busy      = busy_reg;
        t_prio      = prio_reg;
        t_rem       = rem_reg;
        ex_status   = ST_OK;
        ex_src      = SRC_NONE;
        ex_finished = 1'b0;
        push_do     = 1'b0;
        push_data   = fifo_rd_reg;
        level_next  = level_reg;
        if (popped_reg)
        begin
            if (!busy_reg)
            begin
                t_busy = 1'b1;
                t_prio = fifo_rd_reg.prio;
                t_rem  = fifo_rd_reg.dur;
                ex_src = SRC_W'(sel_reg) + 1'b1;
            end
            else if (prio_reg >= fifo_rd_reg.prio)
            begin
                push_data = fifo_rd_reg;
                push_do   = 1'b1;
            end
            else
            begin
                push_data.prio = prio_reg;
                push_data.dur  = rem_reg;
                push_do        = 1'b1;
                t_prio         = fifo_rd_reg.prio;
                t_rem          = fifo_rd_reg.dur;
                ex_src         = SRC_W'(sel_reg) + 1'b1;
            end
            if (push_do)
            begin
                if (stack_full)
                    ex_status = ST_SFULL;
                else
                    level_next = level_reg + 1'b1;
            end
        end
        else if (!busy_reg && (level_reg != '0))
        begin
            level_next = level_reg - 1'b1;
            t_busy     = 1'b1;
            t_prio     = stack_rd_reg.prio;
            t_rem      = stack_rd_reg.dur;
            ex_src     = SRC_STACK;
        end
        if (t_busy)
        begin
            t_rem = (t_rem > tick_amount_reg) ? (t_rem - tick_amount_reg) : '0;
            if (t_rem == '0)
            begin
                ex_finished = 1'b1;
                t_busy      = 1'b0;
                t_prio      = '0;
            end
        end
        else if (ex_status == ST_OK)
        begin
            ex_status = ST_IDLE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        prio_next      = prio_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_go)
                    state_next = S_EXEC;
                else if (idle_go)
                begin
                    out_next.status            = (cmd.drop || enq_full) ? ST_QFULL : ST_OK;
                    out_next.running_valid     = busy_reg;
                    out_next.running_priority  = busy_reg ? prio_reg : '0;
                    out_next.running_remaining = busy_reg ? rem_reg : '0;
                    out_next.finished          = 1'b0;
                    out_next.run_source        = SRC_NONE;
                    out_next.stack_count       = COUNT_W'(level_reg);
                    out_valid_next             = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next                 = S_IDLE;
                    busy_next                  = t_busy;
                    prio_next                  = t_prio;
                    rem_next                   = t_rem;
                    out_next.status            = ex_status;
                    out_next.running_valid     = t_busy;
                    out_next.running_priority  = t_busy ? t_prio : '0;
                    out_next.running_remaining = t_busy ? t_rem : '0;
                    out_next.finished          = ex_finished;
                    out_next.run_source        = ex_src;
                    out_next.stack_count       = COUNT_W'(level_next);
                    out_valid_next             = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (enq_do)
            fifo_mem[fifo_waddr] <= cmd.tsk;
        if (tick_go)
        begin
            fifo_rd_reg  <= fifo_mem[fifo_raddr];
            stack_rd_reg <= stack_mem[stack_raddr];
            popped_reg   <= found;
            sel_reg      <= sel;
        end
        if (exec_done && push_do && !stack_full)
            stack_mem[level_reg[SPW-1:0]] <= push_data;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            level_reg       <= '0;
            busy_reg        <= 1'b0;
            prio_reg        <= '0;
            rem_reg         <= '0;
            tick_amount_reg <= TICK_RESET;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_FIFOS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            prio_reg      <= prio_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (exec_done)
                level_reg <= level_next;
            if (cfg_write_en)
                tick_amount_reg <= cfg_write_data;
            for (int i = 0; i < NUM_FIFOS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ sv/preemptive_priority_task_scheduler_core.sv @@
// Top level of the three-level preemptive priority task scheduler.
//
// Input channel (in_valid/in_ready): command 0 enqueues a task (task_priority,
// task_duration) into FIFO queue_index; command 1 advances one scheduler tick.
// Output channel (out_valid/out_ready): one result transaction per input
// transaction, in order, carrying status, the running task and stack depth.
// Configuration: cfg_write_en/cfg_write_data set tick_amount, the time taken
// from the running task per tick; write it only while the block is idle.
// An enqueue result passes through the front queue and the result register,
// and the engine handles it in its idle state; a tick takes the engine through
// idle and exec (a registered task-memory and stack read, then the decision).
// A 2-entry command queue sits in front of the engine, so input keeps being
// taken while the engine works. When out_ready is low the result register
// holds and the engine stops before writing the next result; the front takes
// input until its queue is full. Reset clears all FIFOs, the stack, the running
// task and sets tick_amount to 1; no clearing pass is needed.
module preemptive_priority_task_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [1:0]  queue_index,
    input  logic [7:0]  task_priority,
    input  logic [15:0] task_duration,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        running_valid,
    output logic [7:0]  running_priority,
    output logic [15:0] running_remaining,
    output logic        finished,
    output logic [2:0]  run_source,
    output logic [4:0]  stack_count
);
    import pts_pkg::*;

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    result_t res;

    pts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .queue_index   (queue_index),
        .task_priority (task_priority),
        .task_duration (task_duration),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    pts_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .res_valid      (out_valid),
        .res            (res),
        .res_ready      (out_ready)
    );

    assign status            = res.status;
    assign running_valid     = res.running_valid;
    assign running_priority  = res.running_priority;
    assign running_remaining = res.running_remaining;
    assign finished          = res.finished;
    assign run_source        = res.run_source;
    assign stack_count       = res.stack_count;

endmodule

@@ sv/pts_checker.sv @@
// Port-level checks for the scheduler core, bound to the top level.
module pts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write_en,
    input logic [15:0] cfg_write_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic        command,
    input logic [1:0]  queue_index,
    input logic [7:0]  task_priority,
    input logic [15:0] task_duration,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        running_valid,
    input logic [7:0]  running_priority,
    input logic [15:0] running_remaining,
    input logic        finished,
    input logic [2:0]  run_source,
    input logic [4:0]  stack_count
);
    import pts_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(running_remaining) && $stable(stack_count))
        else $error("result changed while stalled");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> running_priority == '0 && running_remaining == '0)
        else $error("running fields set with no running task");

    a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> !running_valid && status != ST_QFULL && status != ST_IDLE)
        else $error("finished task still running");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_IDLE |-> !running_valid && run_source == SRC_NONE && !finished)
        else $error("idle tick reports a task");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(stack_count) <= STACK_DEPTH)
        else $error("stack count beyond depth");

endmodule

bind preemptive_priority_task_scheduler_core pts_checker u_pts_checker (.*);

@@ verif/tb_preemptive_priority_task_scheduler_core.sv @@
// Self-checking testbench for the preemptive priority task scheduler core.
`timescale 1ns / 100ps

module tb_preemptive_priority_task_scheduler_core;
    import pts_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_ENQUEUE;
    logic [1:0]  queue_index = '0;
    logic [7:0]  task_priority = '0;
    logic [15:0] task_duration = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        running_valid;
    logic [7:0]  running_priority;
    logic [15:0] running_remaining;
    logic        finished;
    logic [2:0]  run_source;
    logic [4:0]  stack_count;

    // scheduler state as predicted
    task_t       task_fifo[NUM_FIFOS][$];
    task_t       preempted[$];
    logic        running = 1'b0;
    logic [7:0]  cur_prio = '0;
    logic [15:0] cur_rem = '0;
    logic [15:0] tick_amt = TICK_RESET;

    result_t     pending_results[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    int          hold_request = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    preemptive_priority_task_scheduler_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .queue_index       (queue_index),
        .task_priority     (task_priority),
        .task_duration     (task_duration),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .running_valid     (running_valid),
        .running_priority  (running_priority),
        .running_remaining (running_remaining),
        .finished          (finished),
        .run_source        (run_source),
        .stack_count       (stack_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic result_t schedule_step(input logic cmd, input logic [1:0] qi,
                                              input logic [7:0] pr, input logic [15:0] du);
        result_t r;
        task_t   word;
        bit      popped;
        int      src;
        r = '0;
        r.status = ST_OK;
        popped = 1'b0;
        src = 0;
        word = '0;
        if (cmd == CMD_ENQUEUE)
        begin
            if (qi >= NUM_FIFOS)
                r.status = ST_QFULL;
            else if (task_fifo[qi].size() >= FIFO_DEPTH)
                r.status = ST_QFULL;
            else
                task_fifo[qi].push_back({pr, du});
        end
        else
        begin
            for (int i = 0; i < NUM_FIFOS; i++)
            begin
                if (!popped && task_fifo[i].size() != 0)
                begin
                    word = task_fifo[i].pop_front();
                    popped = 1'b1;
                    src = i + 1;
                end
            end
            if (popped)
            begin
                if (!running)
                begin
                    running = 1'b1;
                    cur_prio = word.prio;
                    cur_rem = word.dur;
                    r.run_source = SRC_W'(src);
                end
                else if (cur_prio >= word.prio)
                begin
                    if (preempted.size() >= STACK_DEPTH)
                        r.status = ST_SFULL;
                    else
                        preempted.push_back(word);
                end
                else
                begin
                    if (preempted.size() >= STACK_DEPTH)
                        r.status = ST_SFULL;
                    else
                        preempted.push_back({cur_prio, cur_rem});
                    cur_prio = word.prio;
                    cur_rem = word.dur;
                    r.run_source = SRC_W'(src);
                end
            end
            else if (!running && preempted.size() != 0)
            begin
                word = preempted.pop_back();
                running = 1'b1;
                cur_prio = word.prio;
                cur_rem = word.dur;
                r.run_source = SRC_STACK;
            end
            if (running)
            begin
                if (cur_rem > tick_amt)
                    cur_rem = cur_rem - tick_amt;
                else
                    cur_rem = '0;
                if (cur_rem == 0)
                begin
                    r.finished = 1'b1;
                    running = 1'b0;
                    cur_prio = '0;
                end
            end
            else if (r.status == ST_OK)
            begin
                r.status = ST_IDLE;
            end
        end
        r.running_valid = running;
        r.running_priority = running ? cur_prio : '0;
        r.running_remaining = running ? cur_rem : '0;
        r.stack_count = COUNT_W'(preempted.size());
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with none pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, status);
                check_field("running_valid", want.running_valid, running_valid);
                check_field("running_priority", want.running_priority, running_priority);
                check_field("running_remaining", want.running_remaining, running_remaining);
                check_field("finished", want.finished, finished);
                check_field("run_source", want.run_source, run_source);
                check_field("stack_count", want.stack_count, stack_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [1:0] qi, input logic [7:0] pr,
                             input logic [15:0] du);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        queue_index   <= qi;
        task_priority <= pr;
        task_duration <= du;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(schedule_step(cmd, qi, pr, du));
    endtask

    task automatic write_tick_amount(input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tick_amt = value;
    endtask

    task automatic send_random(input int count, input int tick_pct);
        logic        cmd;
        logic [1:0]  qi;
        logic [7:0]  pr;
        logic [15:0] du;
        int          pick;
        repeat (count)
        begin
            cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_ENQUEUE;
            pick = $urandom_range(0, 15);
            qi = (pick == 0) ? 2'd3 : 2'(pick % NUM_FIFOS);
            case ($urandom_range(0, 7))
                0: pr = 8'd0;
                1: pr = 8'd255;
                2: pr = 8'($urandom_range(0, 3));
                default: pr = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0: du = 16'd0;
                1: du = 16'hFFFF;
                2: du = 16'($urandom);
                default: du = 16'($urandom_range(1, 40));
            endcase
            send_item(cmd, qi, pr, du);
        end
    endtask

    task automatic test_directed();
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd0, 8'd0, 16'd1);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd3, 8'hAA, 16'hAAAA);
        send_item(CMD_ENQUEUE, 2'd0, 8'd10, 16'd5);
        send_item(CMD_TICK, 2'd1, 8'h55, 16'h5555);
        send_item(CMD_ENQUEUE, 2'd2, 8'd200, 16'd2);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd1, 8'd200, 16'd9);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd2, 8'd255, 16'hFFFF);
        send_item(CMD_ENQUEUE, 2'd1, 8'h55, 16'h5555);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd0, 8'd7, 16'd0);
        send_item(CMD_TICK, 2'd3, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_stack_full();
        write_tick_amount(16'hFFFF);
        repeat (6) send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        write_tick_amount(16'd1);
        for (int i = 1; i <= FIFO_DEPTH + 1; i++)
            send_item(CMD_ENQUEUE, 2'd0, 8'(i), 16'd1000);
        repeat (FIFO_DEPTH) send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send_item(CMD_ENQUEUE, 2'd1, 8'd100, 16'd1000);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        // stack full: preempted running task is dropped
        send_item(CMD_ENQUEUE, 2'd1, 8'd200, 16'd1000);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
        // stack full: lower-priority newcomer is dropped
        send_item(CMD_ENQUEUE, 2'd2, 8'd0, 16'd5);
        send_item(CMD_TICK, 2'd0, 8'd0, 16'd0);
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        hold_request = 300;
        send_random(40, 50);
        tx_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [15:0] amounts[5];
        int          counts[5];
        int          pcts[3];
        amounts = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 20)), 16'd2, 16'd1};
        counts  = '{100, 200, 300, 300, 400};
        pcts    = '{30, 50, 70};
        for (int p = 0; p < 5; p++)
        begin
            write_tick_amount(amounts[p]);
            for (int c = 0; c < counts[p]; c += 50)
            begin
                tx_idle = (p < 4) && ($urandom_range(0, 2) != 0);
                rx_idle = (p < 4) && ($urandom_range(0, 2) != 0);
                send_random(50, pcts[$urandom_range(0, 2)]);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stack_full();
        test_backpressure();
        test_random_phases();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
